// ===== hw/rtl/lpr_pkg.sv =====
package lpr_pkg;

	localparam int unsigned MAX_FRAMES_DEF = 16;
	localparam int unsigned PAGE_BITS_DEF  = 8;
	localparam int unsigned CFG_W          = 5;
	localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 5'd4;

	localparam logic KIND_REF   = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] page;
	} lpr_in_t;

	typedef struct packed {
		logic        hit;
		logic        evicted_valid;
		logic [7:0]  evicted_page;
		logic [15:0] fault_total;
	} lpr_out_t;

	// per-beat control broadcast to every cell
	typedef struct packed {
		logic we;
		logic found;
		logic full;
	} lpr_ctl_t;

endpackage

// ===== hw/rtl/lpr_cell.sv =====
module lpr_cell #(
	parameter int unsigned IDX       = 0,
	parameter int unsigned CNT_W     = 5,
	parameter int unsigned PAGE_BITS = lpr_pkg::PAGE_BITS_DEF
) (
	input  logic                 clk,
	input  logic [PAGE_BITS-1:0] pg,
	input  logic [PAGE_BITS-1:0] page_up,
	input  logic                 seen_in,
	input  logic [CNT_W-1:0]     live,
	input  logic [CNT_W-1:0]     top,
	input  lpr_pkg::lpr_ctl_t    ctl,
	output logic [PAGE_BITS-1:0] page,
	output logic                 seen_out
);
	import lpr_pkg::*;

	logic [PAGE_BITS-1:0] page_q;
	logic                 in_live;
	logic                 match;
	logic                 ge_from;
	logic                 at_top;
	logic                 below_top;

	assign in_live   = CNT_W'(IDX) < live;
	assign match     = in_live && (page_q == pg);
	assign seen_out  = seen_in | match;
	assign at_top    = CNT_W'(IDX + 1) == top;
	assign below_top = CNT_W'(IDX + 1) < top;
	// lower bound of the shift window
	assign ge_from   = ctl.found ? seen_out : (ctl.full | ~in_live);
	assign page      = page_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			if (at_top) begin
				page_q <= pg;
			end else if (ge_from && below_top) begin
				page_q <= page_up;
			end
		end
	end

endmodule

// ===== hw/rtl/lru_page_replacement_top.sv =====
// fully associative lru page frame store built as a row of frame cells
// in channel: in_valid / in_stall / in_data, one beat is a page reference or a
//   clear (kind), each beat produces exactly one beat on the out channel
// out channel: out_valid / out_stall / out_data with hit, evicted page and
//   the saturating fault count since the last clear
// cfg channel: cfg_valid / cfg_ready / cfg_data writes frame_count, always ready;
//   zero acts as one frame, values above MAX_FRAMES act as MAX_FRAMES
// output: the registered result appears in the cycle after the input beat is taken
// throughput: one beat per cycle while out_stall is low; every cell compares and
//   shifts at once, so the rate is bounded by the match ripple along the row
// when the receiver stalls, the held result blocks the input channel
//   (in_stall follows out_valid and out_stall) until it is taken
// reset: occupancy and fault count clear, frame_count returns to 4, the
//   output register empties; frame contents stay unknown and are never
//   read before written since only occupied slots are compared
module lru_page_replacement_top #(
	parameter int unsigned MAX_FRAMES = lpr_pkg::MAX_FRAMES_DEF,
	parameter int unsigned PAGE_BITS  = lpr_pkg::PAGE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lpr_pkg::lpr_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lpr_pkg::lpr_out_t              out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lpr_pkg::CFG_W-1:0]      cfg_data
);
	import lpr_pkg::*;

	// count width must hold both MAX_FRAMES and the raw register value
	localparam int unsigned OCC_W = $clog2(MAX_FRAMES + 1);
	localparam int unsigned CW    = (OCC_W > CFG_W) ? OCC_W : CFG_W;

	logic [CFG_W-1:0]     frame_count_q;
	logic [CW-1:0]        occ_q;
	logic [15:0]          fault_q;
	logic                 out_valid_q;
	lpr_out_t             out_q;

	logic                 take;
	logic                 is_ref;
	logic [PAGE_BITS-1:0] pg;
	logic [CW-1:0]        fc_w;
	logic [CW-1:0]        eff;
	logic [CW-1:0]        live;
	logic [CW-1:0]        top;
	logic                 found;
	logic                 full;
	logic [15:0]          fault_nxt;
	lpr_ctl_t             ctl;

	logic [PAGE_BITS-1:0] pages [MAX_FRAMES];
	logic [MAX_FRAMES:0]  seen;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign take      = in_valid & ~in_stall;
	assign is_ref    = (in_data.kind == KIND_REF);
	assign pg        = PAGE_BITS'(in_data.page);

	// effective frame count
	assign fc_w = CW'(frame_count_q);
	always_comb begin
		if (fc_w == '0) begin
			eff = CW'(1);
		end else if (fc_w > CW'(MAX_FRAMES)) begin
			eff = CW'(MAX_FRAMES);
		end else begin
			eff = fc_w;
		end
	end

	assign live  = (occ_q < eff) ? occ_q : eff;
	assign found = seen[MAX_FRAMES];
	assign full  = ~found && (live == eff);

	// one past the highest slot touched by this reference
	always_comb begin
		if (found) begin
			top = live;
		end else if (full) begin
			top = eff;
		end else begin
			top = live + CW'(1);
		end
	end

	assign ctl.we    = take & is_ref;
	assign ctl.found = found;
	assign ctl.full  = full;

	assign fault_nxt = (fault_q == 16'hFFFF) ? fault_q : fault_q + 16'd1;

	// match chain: slot 0 (least recent) at the bottom
	assign seen[0] = 1'b0;
	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		logic [PAGE_BITS-1:0] up;
		if (i == MAX_FRAMES - 1) begin : g_last
			assign up = pages[i];
		end else begin : g_mid
			assign up = pages[i+1];
		end
		lpr_cell #(
			.IDX       (i),
			.CNT_W     (CW),
			.PAGE_BITS (PAGE_BITS)
		) u_cell (
			.clk      (clk),
			.pg       (pg),
			.page_up  (up),
			.seen_in  (seen[i]),
			.live     (live),
			.top      (top),
			.ctl      (ctl),
			.page     (pages[i]),
			.seen_out (seen[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			occ_q         <= '0;
			fault_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				frame_count_q <= cfg_data;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				if (!is_ref) begin
					occ_q   <= '0;
					fault_q <= '0;
				end else if (found) begin
					occ_q <= live;
				end else begin
					occ_q   <= top;
					fault_q <= fault_nxt;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (!is_ref) begin
				out_q <= '0;
			end else begin
				out_q.hit           <= found;
				out_q.evicted_valid <= full;
				out_q.evicted_page  <= full ? 8'(pages[0]) : 8'd0;
				out_q.fault_total   <= found ? fault_q : fault_nxt;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import lpr_pkg::*;

	localparam int unsigned FRAMES    = MAX_FRAMES_DEF;
	localparam int unsigned STALL_CAP = 1000;  // cycles without any beat before giving up
	localparam logic [15:0] FAULT_SAT = 16'hFFFF;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #1 clk = ~clk;

	// dut channels, all held at known values from time zero
	logic             in_valid  = 1'b0;
	logic             in_stall;
	lpr_in_t          in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	lpr_out_t         out_data;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data  = '0;

	lru_page_replacement_top #(
		.MAX_FRAMES(FRAMES),
		.PAGE_BITS (PAGE_BITS_DEF)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// shadow copy of the frame store, oldest page in slot 0
	logic [7:0]       shadow_pages [FRAMES];
	int unsigned      shadow_occupied = 0;
	logic [15:0]      shadow_faults   = '0;
	logic [CFG_W-1:0] shadow_frames   = FRAME_COUNT_RST;

	// results still owed by the dut, oldest first
	lpr_out_t pending_results [$];

	int unsigned error_count = 0;
	int unsigned beats_in    = 0;
	int unsigned beats_out   = 0;
	int unsigned hit_count   = 0;
	int unsigned evict_count = 0;
	int unsigned clear_count = 0;
	int unsigned cfg_writes  = 0;
	int unsigned quiet_cycles = 0;

	// random idling on both sides, switched per phase
	logic idle_en = 1'b0;
	int unsigned stall_left = 0;

	// lru frame store behavior for one reference or clear beat
	function automatic lpr_out_t lru_update(lpr_in_t item);
		lpr_out_t    res;
		int unsigned eff;
		int unsigned live;
		int unsigned where;
		bit          found;
		res   = '0;
		found = 1'b0;
		where = 0;
		if (item.kind == KIND_CLEAR) begin
			shadow_occupied = 0;
			shadow_faults   = '0;
			return res;
		end
		// zero acts as a single frame, oversize saturates at the built depth
		eff = (shadow_frames == 0) ? 1 : shadow_frames;
		if (eff > FRAMES)
			eff = FRAMES;
		// slots above a lowered frame count are dropped here
		live = (shadow_occupied < eff) ? shadow_occupied : eff;
		for (int i = 0; i < live; i++) begin
			if (!found && shadow_pages[i] == item.page) begin
				found = 1'b1;
				where = i;
			end
		end
		if (found) begin
			res.hit = 1'b1;
			for (int s = where + 1; s < live; s++)
				shadow_pages[s-1] = shadow_pages[s];
			shadow_pages[live-1] = item.page;
			shadow_occupied = live;
		end else begin
			if (live < eff) begin
				shadow_pages[live] = item.page;
				shadow_occupied = live + 1;
			end else begin
				res.evicted_valid = 1'b1;
				res.evicted_page  = shadow_pages[0];
				for (int s = 1; s < eff; s++)
					shadow_pages[s-1] = shadow_pages[s];
				shadow_pages[eff-1] = item.page;
				shadow_occupied = eff;
			end
			if (shadow_faults != FAULT_SAT)
				shadow_faults = shadow_faults + 16'd1;
		end
		res.fault_total = shadow_faults;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("tb: mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
		error_count++;
	endtask

	// receiver side: random stall bursts while idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// one monitor for all three channels, sampled at the edge where the beat moves
	always @(posedge clk) begin : beat_monitor
		lpr_out_t want;
		lpr_out_t got;
		bit       moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				shadow_frames = cfg_data;
				cfg_writes++;
				moved = 1'b1;
			end
			// predict on the input beat first, so a result in the same edge finds it
			if (in_valid && !in_stall) begin
				want = lru_update(in_data);
				pending_results.push_back(want);
				beats_in++;
				if (in_data.kind == KIND_CLEAR)
					clear_count++;
				hit_count   += want.hit;
				evict_count += want.evicted_valid;
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				got = out_data;
				beats_out++;
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", got, 0);
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit)
						report_mismatch("hit", got.hit, want.hit);
					if (got.evicted_valid !== want.evicted_valid)
						report_mismatch("evicted_valid", got.evicted_valid, want.evicted_valid);
					if (got.evicted_page !== want.evicted_page)
						report_mismatch("evicted_page", got.evicted_page, want.evicted_page);
					if (got.fault_total !== want.fault_total)
						report_mismatch("fault_total", got.fault_total, want.fault_total);
				end
			end
			// watchdog: too long with nothing moving on any channel
			if (moved) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_CAP) begin
					$display("tb: timeout, %0d results still owed", pending_results.size());
					$display("tb: failure");
					$finish;
				end
			end
		end
	end

	// sender side: optional gap, then hold the beat until it is taken
	task automatic send_beat(input logic kind, input logic [7:0] page);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		in_data.kind <= kind;
		in_data.page <= page;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending and wait until every owed result has arrived
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	// frame_count write, only issued while the store is idle
	task automatic set_frames(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// reset frame count of four: fill, hit at oldest, middle and newest, evict, clear
	task automatic test_fill_hit_evict();
		send_beat(KIND_REF, 8'h00);
		send_beat(KIND_REF, 8'hFF);
		send_beat(KIND_REF, 8'h55);
		send_beat(KIND_REF, 8'hAA);
		send_beat(KIND_REF, 8'h00);   // hit on the oldest slot
		send_beat(KIND_REF, 8'h55);   // hit in the middle
		send_beat(KIND_REF, 8'h55);   // hit on the newest slot
		send_beat(KIND_REF, 8'h0F);   // full, evicts the oldest
		send_beat(KIND_REF, 8'hF0);
		send_beat(KIND_CLEAR, 8'hFF); // page ignored on a clear
		send_beat(KIND_REF, 8'hF0);   // store empty again, so a miss
		drain_results();
	endtask

	// single frame, zero and oversize counts, and shrinking below occupancy
	task automatic test_frame_limits();
		set_frames(5'd1);
		send_beat(KIND_REF, 8'h07);
		send_beat(KIND_REF, 8'h07);
		send_beat(KIND_REF, 8'h08);
		drain_results();
		set_frames(5'd0);             // behaves as one frame
		send_beat(KIND_REF, 8'h09);
		send_beat(KIND_REF, 8'h08);
		drain_results();
		set_frames(5'd8);
		for (int i = 0; i < 6; i++)
			send_beat(KIND_REF, 8'(8'h20 + i));
		drain_results();
		set_frames(5'd2);             // slots 2..5 fall out on the next reference
		send_beat(KIND_REF, 8'h24);   // was resident in a dropped slot, so a miss
		send_beat(KIND_REF, 8'h21);
		drain_results();
		set_frames(5'd31);            // saturates at the built depth
		drain_results();
	endtask

	// random phases over a spread of frame counts, occupancy carried across phases
	task automatic test_random_refs();
		logic [CFG_W-1:0] phase_frames [16];
		logic [7:0]       salt;
		int unsigned      eff;
		int unsigned      pick;
		phase_frames = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd8, 5'd17, 5'd2,
			5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0};
		for (int i = 8; i < 16; i++)
			phase_frames[i] = 5'($urandom_range(0, 31));
		for (int p = 0; p < 16; p++) begin
			idle_en <= (p % 3 != 2);   // every third phase runs flat out
			set_frames(phase_frames[p]);
			eff  = (phase_frames[p] == 0) ? 1 : phase_frames[p];
			if (eff > FRAMES)
				eff = FRAMES;
			salt = 8'($urandom);
			for (int n = 0; n < 106; n++) begin
				pick = $urandom_range(0, 63);
				if (pick == 0)
					send_beat(KIND_CLEAR, 8'($urandom));
				else if (pick < 9)
					send_beat(KIND_REF, 8'($urandom));
				else   // small working set around the frame count: hits and misses mix
					send_beat(KIND_REF, 8'($urandom_range(0, eff + 2)) ^ salt);
			end
			drain_results();
		end
	endtask

	// final stretch with nothing idling: back-to-back evictions on a single frame
	task automatic test_flat_out();
		idle_en <= 1'b0;
		@(posedge clk);
		while (stall_left != 0 || out_stall)
			@(posedge clk);
		set_frames(5'd1);
		send_beat(KIND_CLEAR, 8'h00);
		for (int n = 0; n < 40; n++)
			send_beat(KIND_REF, n[0] ? 8'h3C : 8'hC3);
		send_beat(KIND_REF, 8'h3C);   // hit on the page just loaded
		send_beat(KIND_REF, 8'h5A);
		send_beat(KIND_CLEAR, 8'h00);
		send_beat(KIND_REF, 8'h5A);
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < FRAMES; i++)
			shadow_pages[i] = '0;
		repeat (11) @(posedge clk);
		arst_n  <= 1'b1;
		idle_en <= 1'b1;
		@(posedge clk);

		test_fill_hit_evict();
		test_frame_limits();
		test_random_refs();
		test_flat_out();

		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);
		$display("tb: %0d beats in, %0d results out, %0d frame_count writes",
			beats_in, beats_out, cfg_writes);
		$display("tb: %0d hits, %0d evictions, %0d clears, %0d mismatches",
			hit_count, evict_count, clear_count, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== lru_page_replacement_top.f =====
hw/rtl/lpr_pkg.sv
hw/rtl/lpr_cell.sv
hw/rtl/lru_page_replacement_top.sv
tb/tb.sv
